>>> hdl/rpn_pkg.sv
// rpn_pkg: shared types, constants and helpers for the postfix evaluator
// used by every module under hdl; depends on nothing else
`default_nettype none

package rpn_pkg;

  // stack geometry and word size
  localparam int STACK_DEPTH = 64;
  localparam int WORD_BITS   = 32;
  localparam int SP_BITS     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_BITS   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(WORD_BITS);

  // result item fields
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int OUT_BITS    = ((VALUE_BITS + STATUS_BITS + 7) / 8) * 8;
  localparam int PAD_BITS    = OUT_BITS - VALUE_BITS - STATUS_BITS;

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_DROP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIV0  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_DIV,
    S_EMIT
  } state_t;

  // one classified character
  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  // sticky status: first error of an expression is kept
  function automatic status_t flag_status(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rpn_front.sv
// rpn_front: input handshake and character classification
// depends on rpn_pkg; feeds rpn_queue
`default_nettype none

module rpn_front (
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] symbol
  input  wire logic        s_tlast,   // last
  output logic             q_valid,
  input  wire logic        q_ready,
  output rpn_pkg::cmd_t    q_cmd
);
  import rpn_pkg::*;

  // handshake passes straight to the queue
  assign q_valid  = s_tvalid;
  assign s_tready = q_ready;

  // classify the character
  always_comb begin
    q_cmd.last  = s_tlast;
    q_cmd.digit = 4'd0;
    if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
      q_cmd.op    = OP_PUSH;
      q_cmd.digit = 4'(s_tdata - CH_ZERO);
    end else begin
      case (s_tdata)
        CH_PLUS:  q_cmd.op = OP_ADD;
        CH_MINUS: q_cmd.op = OP_SUB;
        CH_TIMES: q_cmd.op = OP_MUL;
        CH_SLASH: q_cmd.op = OP_DIV;
        default:  q_cmd.op = OP_DROP;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpn_queue.sv
// rpn_queue: short command queue between front and back
// depends on rpn_pkg
`default_nettype none

module rpn_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rpn_pkg::cmd_t in_cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rpn_pkg::cmd_t      out_cmd
);
  import rpn_pkg::*;

  cmd_t                slot [QUEUE_DEPTH];
  logic [QUEUE_BITS-1:0] wptr;
  logic [QUEUE_BITS-1:0] rptr;
  logic [QUEUE_BITS:0]   fill;
  logic                  push;
  logic                  pop;

  assign in_ready  = fill != (QUEUE_BITS + 1)'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign out_cmd   = slot[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= in_cmd;
  end

endmodule

`default_nettype wire

>>> hdl/rpn_div.sv
// rpn_div: iterative signed divider, one quotient bit per cycle, truncating
// depends on rpn_pkg; divisor is never zero when started
`default_nettype none

module rpn_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rpn_pkg::WORD_BITS-1:0] dividend,
  input  wire logic [rpn_pkg::WORD_BITS-1:0] divisor,
  output logic                               done,
  output logic [rpn_pkg::WORD_BITS-1:0]      quotient
);
  import rpn_pkg::*;

  logic                 busy;
  logic [CNT_BITS-1:0]  count;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] den;
  logic                 neg;
  logic [WORD_BITS+1:0] trial;
  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;

  // operand magnitudes
  assign mag_a = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b = divisor[WORD_BITS-1]  ? (~divisor + 1'b1)  : divisor;

  // trial subtraction of the shifted remainder
  assign trial = {1'b0, rem, quo[WORD_BITS-1]} - {2'b00, den};

  assign quotient = neg ? (~quo + 1'b1) : quo;

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(WORD_BITS - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag_a;
      den <= mag_b;
      neg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
    end else if (busy) begin
      if (!trial[WORD_BITS+1]) begin
        rem <= trial[WORD_BITS-1:0];
        quo <= {quo[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[WORD_BITS-2:0], quo[WORD_BITS-1]};
        quo <= {quo[WORD_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpn_back.sv
// rpn_back: executes queued commands on the operand stack, holds the result register
// depends on rpn_pkg and rpn_div
`default_nettype none

module rpn_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_ready,
  input  wire rpn_pkg::cmd_t                   cmd,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rpn_pkg::VALUE_BITS-1:0]       out_value,
  output rpn_pkg::status_t                     out_status
);
  import rpn_pkg::*;

  state_t               state;
  state_t               state_next;
  cmd_t                 cur;
  logic [SP_BITS-1:0]   sp;
  logic [SP_BITS-1:0]   sp_next;
  logic [SP_BITS-1:0]   sp_pop;
  status_t              status;
  status_t              status_next;
  status_t              st_pop;
  logic [WORD_BITS-1:0] tos;
  logic [WORD_BITS-1:0] tos_next;

  // stack below the top word; top lives in tos
  logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic                 rd_en;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] raddr;
  logic [ADDR_BITS-1:0] waddr;

  logic                 div_start;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_quo;
  logic                 emit;

  logic                 has_rhs;
  logic                 has_lhs;
  logic                 stack_full;
  logic                 rhs_zero;
  logic [WORD_BITS-1:0] rhs;
  logic [WORD_BITS-1:0] lhs;

  // operand selection in the execute step
  assign has_rhs    = sp != '0;
  assign has_lhs    = sp >= SP_BITS'(2);
  assign stack_full = sp == SP_BITS'(STACK_DEPTH);
  assign rhs        = has_rhs ? tos : '0;
  assign lhs        = has_lhs ? rdata : '0;
  assign rhs_zero   = rhs == '0;
  assign sp_pop     = has_lhs ? (sp - SP_BITS'(2)) : '0;
  assign st_pop     = has_lhs ? status : flag_status(status, ST_UNDER);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_PUSH) state_next = cmd.last ? S_EMIT : S_IDLE;
          else                   state_next = S_OPER;
        end
      end
      S_OPER: begin
        if (cur.op == OP_DIV && !rhs_zero) state_next = S_DIV;
        else                               state_next = cur.last ? S_EMIT : S_IDLE;
      end
      S_DIV: begin
        if (div_done) state_next = cur.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready = state == S_IDLE;
    rd_en     = (state == S_IDLE) && cmd_valid && (cmd.op != OP_PUSH);
    raddr     = (cmd.op == OP_DROP) ? ADDR_BITS'(sp - SP_BITS'(3))
                                    : ADDR_BITS'(sp - SP_BITS'(2));
    wr_en     = (state == S_IDLE) && cmd_valid && (cmd.op == OP_PUSH) &&
                has_rhs && !stack_full;
    waddr     = ADDR_BITS'(sp - SP_BITS'(1));
    div_start = (state == S_OPER) && (cur.op == OP_DIV) && !rhs_zero;
    emit      = (state == S_EMIT) && (!out_valid || out_ready);
  end

  // stack pointer, top word and sticky status
  always_comb begin
    sp_next     = sp;
    tos_next    = tos;
    status_next = status;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.op == OP_PUSH) begin
          if (stack_full) begin
            status_next = flag_status(status, ST_OVER);
          end else begin
            sp_next  = sp + 1'b1;
            tos_next = WORD_BITS'(cmd.digit);
          end
        end
      end
      S_OPER: begin
        status_next = st_pop;
        case (cur.op)
          OP_ADD: begin
            tos_next = lhs + rhs;
            sp_next  = sp_pop + 1'b1;
          end
          OP_SUB: begin
            tos_next = lhs - rhs;
            sp_next  = sp_pop + 1'b1;
          end
          OP_MUL: begin
            tos_next = WORD_BITS'(lhs * rhs);
            sp_next  = sp_pop + 1'b1;
          end
          OP_DIV: begin
            sp_next = sp_pop + 1'b1;
            if (rhs_zero) begin
              tos_next    = '0;
              status_next = flag_status(st_pop, ST_DIV0);
            end
          end
          default: begin
            tos_next = rdata;
            sp_next  = sp_pop;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) tos_next = div_quo;
      end
      S_EMIT: begin
        if (emit) begin
          sp_next     = '0;
          status_next = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      status    <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      status <= status_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tos <= tos_next;
    if (state == S_IDLE && cmd_valid) cur <= cmd;
    if (emit) begin
      out_value  <= has_rhs ? VALUE_BITS'(tos) : '0;
      out_status <= has_rhs ? status : flag_status(status, ST_UNDER);
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[waddr] <= tos;
    if (rd_en) rdata <= stack_mem[raddr];
  end

  // iterative divider for the / command
  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lhs),
    .divisor  (rhs),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

`default_nettype wire

>>> hdl/postfix_expression_evaluator.sv
// postfix_expression_evaluator: top level, front, command queue and execution back end
// back end per character: a digit is pushed in the idle state; + - * / and other characters
// pass the operate state, and / with a nonzero divisor then waits for the iterative divider
// a last character adds the emit state, which waits for a free output and registers m_tvalid
// the two-entry queue takes characters while the back end works, then stalls
// rst is synchronous: stack empty, status clear, no result pending; stack words stay undefined
`default_nettype none

module postfix_expression_evaluator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // [7:0] symbol
  input  wire logic                        s_tlast,  // last
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [rpn_pkg::OUT_BITS-1:0]     m_tdata   // [31:0] value, [33:32] status, zeros above
);
  import rpn_pkg::*;

  logic                  fq_valid;
  logic                  fq_ready;
  cmd_t                  fq_cmd;
  logic                  qb_valid;
  logic                  qb_ready;
  cmd_t                  qb_cmd;
  logic [VALUE_BITS-1:0] res_value;
  status_t               res_status;

  // classification front
  rpn_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_cmd    (fq_cmd)
  );

  // decoupling queue
  rpn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_cmd   (qb_cmd)
  );

  // execution back end
  rpn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (res_value),
    .out_status (res_status)
  );

  // result packing
  assign m_tdata = {{PAD_BITS{1'b0}}, res_status, res_value};

endmodule

`default_nettype wire

>>> hdl/rpn_checker.sv
// rpn_checker: port-level assertions for the postfix evaluator, bound to the top level
// depends on rpn_pkg
`default_nettype none

module rpn_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [rpn_pkg::OUT_BITS-1:0] m_tdata
);
  import rpn_pkg::*;

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // reset leaves the command queue empty, so input is taken
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // a stalled result transaction holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // padding above the status field is zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_BITS-1:VALUE_BITS+STATUS_BITS] == '0)
    else $error("result padding not zero");

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (.*);

`default_nettype wire
